@@ hdl/fuzzy_overlap_top_k_unit_macros.svh @@
// assertion macros for the fuzzy overlap top-k unit
// expects clk and rst_n in the scope of use
`ifndef FUZZY_OVERLAP_TOP_K_UNIT_MACROS_SVH
`define FUZZY_OVERLAP_TOP_K_UNIT_MACROS_SVH

// same-cycle implication
`define FOTK_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FOTK_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/fotk_pkg.sv @@
// package for the fuzzy overlap top-k unit
// widths, stream packing and sequencer state type; no dependencies
`timescale 1ns / 1ps

package fotk_pkg;

    localparam int TOP_K_DEF   = 32;

    localparam int VAL_W       = 16;
    localparam int WORD_W      = 16;
    localparam int SCORE_W     = 16;
    localparam int RANK_W      = 5;
    localparam int PROD_W      = 2 * VAL_W;
    localparam int TERM_W      = PROD_W + 1;
    localparam int INTER_W     = 40;
    localparam int DIV_W       = 41;
    localparam int DIV_STEPS   = SCORE_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 1;
    localparam int OUT_PAD_W   = OUT_TDATA_W - RANK_W - WORD_W - SCORE_W;

    localparam logic OP_ELEMENT = 1'b0;
    localparam logic OP_REPORT  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_TERM,
        ST_ACC,
        ST_CMP,
        ST_DIV,
        ST_INS,
        ST_RPT
    } state_t;

endpackage

@@ hdl/fuzzy_overlap_top_k_unit.sv @@
// fuzzy overlap similarity scoring with a descending top-k table
// depends on fotk_pkg and fuzzy_overlap_top_k_unit_macros.svh
`timescale 1ns / 1ps
`include "fuzzy_overlap_top_k_unit_macros.svh"

// usage
// s_axis carries element and report transactions; tuser selects the kind
// (0 element, 1 report and clear), tlast marks the last element of a candidate.
// an element is multiplied, its divisor term formed and both sums updated in
// the multiply, term and accumulate states after acceptance; no new
// transaction is taken until the element is through them. the last element
// of a candidate then adds a check state, 16 steps of the shared restoring
// divide step (one 42-bit compare and subtract per cycle) and an insert
// state; the divide is skipped when the divisor is zero or the score saturates.
// a report shifts the table out one slot per cycle on m_axis while the
// receiver accepts, TOP_K transactions with tlast on the final slot; the first
// goes to the output register from the report state; the table is left cleared.
// m_axis has an output register; when the receiver stalls the report
// waits, while element work keeps going once the report has been loaded.
// cfg_wr_en writes symmetric_mode (1 union divisor, 0 query-sum divisor).
// reset clears both sums and the table and sets symmetric_mode.
module fuzzy_overlap_top_k_unit #(
    parameter int TOP_K = fotk_pkg::TOP_K_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_wr_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // query_value, candidate_value, word_index
    input  logic [fotk_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // op
    input  logic [fotk_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // rank, best_word, best_score, zero pad
    output logic [fotk_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // slot_valid
    output logic [fotk_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    output logic                             m_axis_tlast
);

    import fotk_pkg::*;

    localparam int CNT_W = (TOP_K > 1) ? $clog2(TOP_K) : 1;

    state_t state_reg, state_next;

    logic                mode_reg;
    logic [VAL_W-1:0]    qv_reg, qv_next;
    logic [VAL_W-1:0]    mv_reg, mv_next;
    logic [WORD_W-1:0]   word_in_reg, word_in_next;
    logic                last_reg, last_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [TERM_W-1:0]   term_reg, term_next;
    logic [INTER_W-1:0]  inter_reg, inter_next;
    logic [DIV_W-1:0]    div_reg, div_next;
    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]    dsr_reg, dsr_next;
    logic [SCORE_W-1:0]  quot_reg, quot_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic [SCORE_W-1:0]  score_reg [TOP_K];
    logic [SCORE_W-1:0]  score_next [TOP_K];
    logic [WORD_W-1:0]   tword_reg [TOP_K];
    logic [WORD_W-1:0]   tword_next [TOP_K];
    logic [TOP_K-1:0]    filled_reg, filled_next;
    logic [TOP_K-1:0]    gt;

    logic                out_valid_reg, out_valid_next;
    logic [RANK_W-1:0]   out_rank_reg, out_rank_next;
    logic [WORD_W-1:0]   out_word_reg, out_word_next;
    logic [SCORE_W-1:0]  out_score_reg, out_score_next;
    logic                out_flag_reg, out_flag_next;
    logic                out_last_reg, out_last_next;

    logic                take_in;
    logic                load_out;
    logic                out_free;
    logic                rpt_last;
    logic                div_done;

    logic [DIV_W:0]      rem_dbl;
    logic [DIV_W:0]      rem_diff;
    logic                rem_ge;
    logic [TERM_W-1:0]   union_sum;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign rpt_last = (cnt_reg == CNT_W'(TOP_K - 1));
    assign div_done = (step_reg == STEP_W'(DIV_STEPS - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = (s_axis_tuser[0] == OP_REPORT) ? ST_RPT : ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_TERM;
            ST_TERM: state_next = ST_ACC;
            ST_ACC:  state_next = last_reg ? ST_CMP : ST_IDLE;
            ST_CMP:
            begin
                if ((div_reg == '0) || ({1'b0, inter_reg} >= div_reg))
                begin
                    state_next = ST_INS;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:  state_next = div_done ? ST_INS : ST_DIV;
            ST_INS:  state_next = ST_IDLE;
            ST_RPT:
            begin
                if (out_free && rpt_last)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        take_in       = (state_reg == ST_IDLE) && s_axis_tvalid;
        load_out      = (state_reg == ST_RPT) && out_free;
    end

    // shared divide step
    always_comb
    begin
        rem_dbl  = {rem_reg, 1'b0};
        rem_ge   = (rem_dbl >= {1'b0, dsr_reg});
        rem_diff = rem_dbl - {1'b0, dsr_reg};
    end

    assign union_sum = {1'b0, qv_reg, {VAL_W{1'b0}}} + {1'b0, mv_reg, {VAL_W{1'b0}}};

    // insert position compare, one per slot
    always_comb
    begin
        for (int i = 0; i < TOP_K; i++)
        begin
            gt[i] = (quot_reg > score_reg[i]);
        end
    end

    // datapath
    always_comb
    begin
        qv_next      = qv_reg;
        mv_next      = mv_reg;
        word_in_next = word_in_reg;
        last_next    = last_reg;
        prod_next    = prod_reg;
        term_next    = term_reg;
        inter_next   = inter_reg;
        div_next     = div_reg;
        rem_next     = rem_reg;
        dsr_next     = dsr_reg;
        quot_next    = quot_reg;
        step_next    = step_reg;
        cnt_next     = cnt_reg;
        score_next   = score_reg;
        tword_next   = tword_reg;
        filled_next  = filled_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take_in)
                begin
                    qv_next      = s_axis_tdata[VAL_W-1:0];
                    mv_next      = s_axis_tdata[2*VAL_W-1:VAL_W];
                    word_in_next = s_axis_tdata[2*VAL_W+WORD_W-1:2*VAL_W];
                    last_next    = s_axis_tlast;
                    cnt_next     = '0;
                end
            end
            ST_MUL:
            begin
                prod_next = qv_reg * mv_reg;
            end
            ST_TERM:
            begin
                if (mode_reg)
                begin
                    term_next = union_sum - {1'b0, prod_reg};
                end
                else
                begin
                    term_next = {1'b0, qv_reg, {VAL_W{1'b0}}};
                end
            end
            ST_ACC:
            begin
                inter_next = inter_reg + INTER_W'(prod_reg);
                div_next   = div_reg + DIV_W'(term_reg);
            end
            ST_CMP:
            begin
                rem_next   = {1'b0, inter_reg};
                dsr_next   = div_reg;
                step_next  = '0;
                inter_next = '0;
                div_next   = '0;
                if (div_reg == '0)
                begin
                    quot_next = '0;
                end
                else if ({1'b0, inter_reg} >= div_reg)
                begin
                    quot_next = '1;
                end
                else
                begin
                    quot_next = '0;
                end
            end
            ST_DIV:
            begin
                rem_next  = rem_ge ? rem_diff[DIV_W-1:0] : rem_dbl[DIV_W-1:0];
                quot_next = {quot_reg[SCORE_W-2:0], rem_ge};
                step_next = step_reg + STEP_W'(1);
            end
            ST_INS:
            begin
                if (gt[0])
                begin
                    score_next[0]  = quot_reg;
                    tword_next[0]  = word_in_reg;
                    filled_next[0] = 1'b1;
                end
                for (int i = 1; i < TOP_K; i++)
                begin
                    if (gt[i])
                    begin
                        if (gt[i-1])
                        begin
                            score_next[i]  = score_reg[i-1];
                            tword_next[i]  = tword_reg[i-1];
                            filled_next[i] = filled_reg[i-1];
                        end
                        else
                        begin
                            score_next[i]  = quot_reg;
                            tword_next[i]  = word_in_reg;
                            filled_next[i] = 1'b1;
                        end
                    end
                end
            end
            ST_RPT:
            begin
                if (load_out)
                begin
                    for (int i = 0; i < TOP_K - 1; i++)
                    begin
                        score_next[i]  = score_reg[i+1];
                        tword_next[i]  = tword_reg[i+1];
                        filled_next[i] = filled_reg[i+1];
                    end
                    score_next[TOP_K-1]  = '0;
                    tword_next[TOP_K-1]  = '0;
                    filled_next[TOP_K-1] = 1'b0;
                    cnt_next             = cnt_reg + CNT_W'(1);
                end
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_rank_next  = out_rank_reg;
        out_word_next  = out_word_reg;
        out_score_next = out_score_reg;
        out_flag_next  = out_flag_reg;
        out_last_next  = out_last_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_rank_next  = RANK_W'(cnt_reg);
            out_word_next  = tword_reg[0];
            out_score_next = score_reg[0];
            out_flag_next  = filled_reg[0];
            out_last_next  = rpt_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= 1'b1;
            inter_reg     <= '0;
            div_reg       <= '0;
            step_reg      <= '0;
            cnt_reg       <= '0;
            filled_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TOP_K; i++)
            begin
                score_reg[i] <= '0;
                tword_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            inter_reg     <= inter_next;
            div_reg       <= div_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            filled_reg    <= filled_next;
            out_valid_reg <= out_valid_next;
            score_reg     <= score_next;
            tword_reg     <= tword_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qv_reg        <= qv_next;
        mv_reg        <= mv_next;
        word_in_reg   <= word_in_next;
        last_reg      <= last_next;
        prod_reg      <= prod_next;
        term_reg      <= term_next;
        rem_reg       <= rem_next;
        dsr_reg       <= dsr_next;
        quot_reg      <= quot_next;
        out_rank_reg  <= out_rank_next;
        out_word_reg  <= out_word_next;
        out_score_reg <= out_score_next;
        out_flag_reg  <= out_flag_next;
        out_last_reg  <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_score_reg, out_word_reg, out_rank_reg};
    assign m_axis_tuser  = out_flag_reg;
    assign m_axis_tlast  = out_last_reg;

    // divide remainder stays below the divisor
    `FOTK_ASSERT_IMP(a_rem_below_dsr, state_reg == ST_DIV, rem_reg < dsr_reg, "remainder overflow")

    // divide runs its fixed number of steps
    `FOTK_ASSERT_NXT(a_div_len, (state_reg == ST_DIV) && div_done, state_reg == ST_INS, "divide length")

    // report ends after the final slot is loaded
    `FOTK_ASSERT_NXT(a_rpt_end, load_out && rpt_last, state_reg == ST_IDLE && m_axis_tlast, "report end")

    for (genvar g = 0; g < TOP_K; g++)
    begin : g_chk
        // empty slots hold a zero score
        `FOTK_ASSERT_IMP(a_empty_zero, !filled_reg[g], score_reg[g] == '0, "empty slot score")
        if (g > 0)
        begin : g_ord
            // table stays in descending order
            `FOTK_ASSERT_IMP(a_order, 1'b1, score_reg[g-1] >= score_reg[g], "table order")
        end
    end

endmodule
